// ===== rtl/core/ita_pkg.sv =====
// Shared types, constants and helpers for the integer to padded ASCII formatter.
package ita_pkg;

	localparam int MAX_WIDTH_DEF   = 63;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int DIGIT_BUFFER    = 12;
	localparam int TEXT_MAX        = DIGIT_BUFFER - 1;
	localparam int LEN_W           = 4;
	localparam int WIDTH_W         = 6;
	localparam int CHAR_W          = 7;
	localparam int VALUE_W         = 32;

	localparam logic [VALUE_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int                 DIV10_SHIFT = 35;

	localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;

	typedef enum logic [1:0] {
		MODE_SDEC = 2'd0,
		MODE_UDEC = 2'd1,
		MODE_LHEX = 2'd2,
		MODE_UHEX = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_CONV,
		FR_SIGN,
		FR_PUSH
	} front_state_t;

	typedef struct packed {
		logic [TEXT_MAX-1:0][CHAR_W-1:0] text;
		logic [LEN_W-1:0]                len;
		logic                            lead_minus;
		logic [WIDTH_W-1:0]              pad_cnt;
		logic                            left_just;
		logic [CHAR_W-1:0]               pad_char;
	} desc_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
		logic [CHAR_W-1:0] res;
		if (d < 4'd10) begin
			res = CH_ZERO + CHAR_W'(d);
		end else if (upper) begin
			res = CH_UPPER_A + CHAR_W'(d) - CHAR_W'(10);
		end else begin
			res = CH_LOWER_A + CHAR_W'(d) - CHAR_W'(10);
		end
		return res;
	endfunction

endpackage

// ===== rtl/core/ita_num_if.sv =====
// Input channel: one integer with its conversion mode, field width and pad flags.
interface ita_num_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] value;
	logic [5:0]  field_width;
	logic [1:0]  pad_flags;

	modport source (output valid, mode, value, field_width, pad_flags, input ready);
	modport sink   (input valid, mode, value, field_width, pad_flags, output ready);
endinterface

// ===== rtl/core/ita_text_if.sv =====
// Output channel: one ASCII character per item with an end-of-field mark.
interface ita_text_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       last;

	modport source (output valid, out_char, last, input ready);
	modport sink   (input valid, out_char, last, output ready);
endinterface

// ===== rtl/core/ita_front.sv =====
// Front end: accept an item, convert the value to digits, build a field descriptor.
module ita_front
	import ita_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	ita_num_if.sink num,
	output logic    push,
	output desc_t   push_data,
	input  logic    full
);

	front_state_t state_q, state_d;

	logic [VALUE_W-1:0]              u_q;
	logic                            hex_q;
	logic                            upper_q;
	logic                            neg_q;
	logic [WIDTH_W-1:0]              width_q;
	logic                            left_just_q;
	logic                            pad_zero_q;
	logic [TEXT_MAX-1:0][CHAR_W-1:0] text_q;
	logic [LEN_W-1:0]                len_q;

	logic [2*VALUE_W-1:0] prod;
	logic [VALUE_W-1:0]   quo;
	logic [3:0]           dig;
	logic                 lead;
	logic                 in_neg;
	logic [WIDTH_W-1:0]   w_eff;
	logic [WIDTH_W-1:0]   len_ext;

	assign prod   = (2*VALUE_W)'(u_q) * (2*VALUE_W)'(DIV10_RECIP);
	assign in_neg = (num.mode == MODE_SDEC) && num.value[VALUE_W-1];
	assign lead   = neg_q && (width_q != '0) && pad_zero_q;

	always_comb begin
		if (hex_q) begin
			quo = {4'b0, u_q[VALUE_W-1:4]};
			dig = u_q[3:0];
		end else begin
			quo = {3'b0, prod[2*VALUE_W-1:DIV10_SHIFT]};
			dig = u_q[3:0] - {quo[0], 3'b000} - {quo[2:0], 1'b0};
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_IDLE: begin
				if (num.valid) begin
					state_d = FR_CONV;
				end
			end
			FR_CONV: begin
				if (quo == '0) begin
					state_d = (neg_q && !lead) ? FR_SIGN : FR_PUSH;
				end
			end
			FR_SIGN: begin
				state_d = FR_PUSH;
			end
			FR_PUSH: begin
				if (!full) begin
					state_d = FR_IDLE;
				end
			end
			default: begin
				state_d = FR_IDLE;
			end
		endcase
	end

	always_comb begin
		num.ready = 1'b0;
		push      = 1'b0;
		case (state_q)
			FR_IDLE: begin
				num.ready = 1'b1;
			end
			FR_PUSH: begin
				push = !full;
			end
			default: begin
				num.ready = 1'b0;
				push      = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			FR_IDLE: begin
				if (num.valid) begin
					u_q         <= in_neg ? (VALUE_W'(0) - num.value) : num.value;
					hex_q       <= (num.mode == MODE_LHEX) || (num.mode == MODE_UHEX);
					upper_q     <= (num.mode == MODE_UHEX);
					neg_q       <= in_neg;
					width_q     <= (num.field_width > WIDTH_W'(MAX_WIDTH)) ?
						WIDTH_W'(MAX_WIDTH) : num.field_width;
					left_just_q <= num.pad_flags[0];
					pad_zero_q  <= num.pad_flags[1];
					len_q       <= '0;
				end
			end
			FR_CONV: begin
				text_q <= {text_q[TEXT_MAX-2:0], digit_char(dig, upper_q)};
				len_q  <= len_q + LEN_W'(1);
				u_q    <= quo;
			end
			FR_SIGN: begin
				text_q <= {text_q[TEXT_MAX-2:0], CH_MINUS};
				len_q  <= len_q + LEN_W'(1);
			end
			default: begin
				len_q <= len_q;
			end
		endcase
	end

	assign w_eff   = lead ? (width_q - WIDTH_W'(1)) : width_q;
	assign len_ext = WIDTH_W'(len_q);

	always_comb begin
		push_data.text       = text_q;
		push_data.len        = len_q;
		push_data.lead_minus = lead;
		push_data.pad_cnt    = (len_ext >= w_eff) ? '0 : (w_eff - len_ext);
		push_data.left_just  = left_just_q;
		push_data.pad_char   = pad_zero_q ? CH_ZERO : CH_SPACE;
	end

endmodule

// ===== rtl/core/ita_queue.sv =====
// Short descriptor queue between the front end and the character emitter.
module ita_queue
	import ita_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_data,
	output logic  full,
	input  logic  pop,
	output desc_t pop_data,
	output logic  not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	desc_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/ita_back.sv =====
// Back end: walk a field descriptor and emit one character per cycle while the output is ready.
module ita_back
	import ita_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  desc_t         q_data,
	output logic          pop,
	ita_text_if.source    text
);

	logic [TEXT_MAX-1:0][CHAR_W-1:0] text_q;
	logic                            minus_q;
	logic [WIDTH_W-1:0]              lpad_q;
	logic [LEN_W-1:0]                tlen_q;
	logic [WIDTH_W-1:0]              rpad_q;
	logic [CHAR_W-1:0]               pad_char_q;

	logic              ovalid_q;
	logic [CHAR_W-1:0] ochar_q;
	logic              olast_q;

	logic               busy;
	logic               advance;
	logic [CHAR_W-1:0]  ch;
	logic               minus_n;
	logic [WIDTH_W-1:0] lpad_n;
	logic [LEN_W-1:0]   tlen_n;
	logic [WIDTH_W-1:0] rpad_n;
	logic               shift;
	logic               last_n;

	assign busy    = minus_q || (lpad_q != '0) || (tlen_q != '0) || (rpad_q != '0);
	assign pop     = !busy && q_valid;
	assign advance = busy && (!ovalid_q || text.ready);

	always_comb begin
		minus_n = minus_q;
		lpad_n  = lpad_q;
		tlen_n  = tlen_q;
		rpad_n  = rpad_q;
		shift   = 1'b0;
		if (minus_q) begin
			ch      = CH_MINUS;
			minus_n = 1'b0;
		end else if (lpad_q != '0) begin
			ch     = pad_char_q;
			lpad_n = lpad_q - WIDTH_W'(1);
		end else if (tlen_q != '0) begin
			ch     = text_q[0];
			tlen_n = tlen_q - LEN_W'(1);
			shift  = 1'b1;
		end else begin
			ch     = pad_char_q;
			rpad_n = rpad_q - WIDTH_W'(1);
		end
		last_n = !minus_n && (lpad_n == '0) && (tlen_n == '0) && (rpad_n == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minus_q  <= 1'b0;
			lpad_q   <= '0;
			tlen_q   <= '0;
			rpad_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				minus_q <= q_data.lead_minus;
				lpad_q  <= q_data.left_just ? '0 : q_data.pad_cnt;
				tlen_q  <= q_data.len;
				rpad_q  <= q_data.left_just ? q_data.pad_cnt : '0;
			end else if (advance) begin
				minus_q <= minus_n;
				lpad_q  <= lpad_n;
				tlen_q  <= tlen_n;
				rpad_q  <= rpad_n;
			end
			if (advance) begin
				ovalid_q <= 1'b1;
			end else if (text.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			text_q     <= q_data.text;
			pad_char_q <= q_data.pad_char;
		end else if (advance && shift) begin
			text_q <= {CHAR_W'(0), text_q[TEXT_MAX-1:1]};
		end
		if (advance) begin
			ochar_q <= ch;
			olast_q <= last_n;
		end
	end

	assign text.valid    = ovalid_q;
	assign text.out_char = ochar_q;
	assign text.last     = olast_q;

endmodule

// ===== rtl/core/integer_to_padded_ascii.sv =====
// Top level: integer to padded ASCII field formatter, one character per output item.
// Path: the front takes the input item and converts one digit per state step (up to 10
// decimal or 8 hex, reciprocal multiply for ten), adds a sign step if needed, then queues
// the descriptor; the emitter loads it and registers each character.
// Throughput: the emitter sends one character per cycle while the output is ready, with a
// load step per field; the front handles one item at a time, overlapped with the emitter via the queue.
// Reset: arst_n clears all control state at once; no clearing pass is needed.
module integer_to_padded_ascii
	import ita_pkg::*;
#(
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ita_num_if.sink     num,
	ita_text_if.source  text
);

	logic  push;
	desc_t push_data;
	logic  full;
	logic  pop;
	desc_t pop_data;
	logic  not_empty;

	ita_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.num       (num),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	ita_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	ita_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (not_empty),
		.q_data  (pop_data),
		.pop     (pop),
		.text    (text)
	);

endmodule

// ===== dv/tb.sv =====
// Testbench for integer_to_padded_ascii: directed, random and backpressure fields.
module tb;
	import ita_pkg::*;

	localparam int LEFT_JUST_BIT = 0;
	localparam int PAD_ZERO_BIT  = 1;

	localparam logic [1:0] PAD_SPACE_LEFT  = 2'd0;
	localparam logic [1:0] PAD_SPACE_RIGHT = 2'd1;
	localparam logic [1:0] PAD_ZERO_LEFT   = 2'd2;
	localparam logic [1:0] PAD_ZERO_RIGHT  = 2'd3;

	localparam int RANDOM_FIELDS    = 300;
	localparam int SINK_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES    = 40;
	localparam int MAX_PRINTED      = 40;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_char_t;

	logic clk;
	logic arst_n;

	ita_num_if  num_ch ();
	ita_text_if text_ch ();

	integer_to_padded_ascii dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch),
		.text   (text_ch)
	);

	text_char_t pending_chars [$];
	int         mismatches;
	int         fields_sent;
	int         fields_done;
	int         chars_checked;
	int         mode_fields [4];
	bit         src_gaps;
	bit         sink_gaps;
	int         hold_asked;
	int         hold_seen;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("MISMATCH at %0t: %s", $time, what);
		end
	endtask

	function automatic void format_field(mode_t fmt, logic [31:0] val, logic [5:0] fw,
			logic [1:0] flags);
		logic [CHAR_W-1:0] digits [DIGIT_BUFFER];
		text_char_t        field [$];
		logic [31:0]       mag;
		logic [31:0]       base;
		logic [3:0]        d;
		logic [CHAR_W-1:0] pad_ch;
		logic [CHAR_W-1:0] alpha;
		int                len;
		int                wid;
		int                pad_n;
		bit                neg;
		mag    = val;
		len    = 0;
		wid    = fw;
		neg    = 1'b0;
		base   = (fmt == MODE_LHEX || fmt == MODE_UHEX) ? 32'd16 : 32'd10;
		alpha  = (fmt == MODE_UHEX) ? CH_UPPER_A : CH_LOWER_A;
		pad_ch = flags[PAD_ZERO_BIT] ? CH_ZERO : CH_SPACE;
		if (wid > MAX_WIDTH_DEF) begin
			wid = MAX_WIDTH_DEF;
		end
		if (fmt == MODE_SDEC && val[31]) begin
			neg = 1'b1;
			mag = 32'd0 - val;
		end
		do begin
			d = 4'(mag % base);
			digits[len] = (d < 4'd10) ? CH_ZERO + CHAR_W'(d) :
				alpha + CHAR_W'(d) - CHAR_W'(10);
			len++;
			mag = mag / base;
		end while (mag != 32'd0);
		if (neg) begin
			if (wid != 0 && flags[PAD_ZERO_BIT]) begin
				field.push_back('{CH_MINUS, 1'b0});
				wid--;
			end else begin
				digits[len] = CH_MINUS;
				len++;
			end
		end
		pad_n = (len >= wid) ? 0 : wid - len;
		if (!flags[LEFT_JUST_BIT]) begin
			repeat (pad_n) field.push_back('{pad_ch, 1'b0});
		end
		for (int k = len - 1; k >= 0; k--) begin
			field.push_back('{digits[k], 1'b0});
		end
		if (flags[LEFT_JUST_BIT]) begin
			repeat (pad_n) field.push_back('{pad_ch, 1'b0});
		end
		field[field.size() - 1].last = 1'b1;
		foreach (field[i]) begin
			pending_chars.push_back(field[i]);
		end
	endfunction

	task automatic send_num(mode_t fmt, logic [31:0] val, logic [5:0] fw, logic [1:0] flags);
		while (src_gaps && $urandom_range(99) < 15) begin
			num_ch.valid <= 1'b0;
			@(posedge clk);
		end
		num_ch.valid       <= 1'b1;
		num_ch.mode        <= fmt;
		num_ch.value       <= val;
		num_ch.field_width <= fw;
		num_ch.pad_flags   <= flags;
		@(posedge clk);
		while (!num_ch.ready) @(posedge clk);
		format_field(fmt, val, fw, flags);
		fields_sent++;
		mode_fields[fmt]++;
	endtask

	// hold input quiet until every expected character is out
	task automatic wait_fields_done();
		num_ch.valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(7))
			0: v = $urandom_range(20);
			1: v = 32'h8000_0000 + $urandom_range(3);
			2: v = 32'h7FFF_FFFF - $urandom_range(3);
			3: v = 32'hFFFF_FFFF - $urandom_range(20);
			4: v = (32'd1 << $urandom_range(31)) - $urandom_range(1);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [5:0] pick_width();
		int r;
		r = $urandom_range(99);
		if (r < 70) begin
			return 6'($urandom_range(12));
		end else if (r < 90) begin
			return 6'($urandom_range(24));
		end
		return 6'($urandom_range(63));
	endfunction

	task automatic test_directed();
		send_num(MODE_SDEC, 32'd0, 6'd0, PAD_SPACE_LEFT);
		send_num(MODE_SDEC, 32'h8000_0000, 6'd0, PAD_SPACE_LEFT);
		send_num(MODE_SDEC, 32'h7FFF_FFFF, 6'd63, PAD_SPACE_RIGHT);
		send_num(MODE_SDEC, 32'hFFFF_FFFB, 6'd10, PAD_SPACE_LEFT);
		send_num(MODE_SDEC, 32'hFFFF_FFFB, 6'd10, PAD_SPACE_RIGHT);
		send_num(MODE_SDEC, 32'hFFFF_FFFB, 6'd10, PAD_ZERO_LEFT);
		send_num(MODE_SDEC, 32'hFFFF_FFFB, 6'd10, PAD_ZERO_RIGHT);
		send_num(MODE_SDEC, 32'hFFFF_FFFB, 6'd0, PAD_ZERO_LEFT);
		send_num(MODE_SDEC, 32'hFFFF_FFFF, 6'd1, PAD_ZERO_LEFT);
		send_num(MODE_SDEC, 32'hFFFF_FFFF, 6'd2, PAD_ZERO_RIGHT);
		send_num(MODE_SDEC, 32'h8000_0000, 6'd63, PAD_ZERO_LEFT);
		send_num(MODE_UDEC, 32'hFFFF_FFFF, 6'd10, PAD_ZERO_LEFT);
		send_num(MODE_UDEC, 32'h8000_0000, 6'd5, PAD_SPACE_LEFT);
		send_num(MODE_UDEC, 32'd0, 6'd63, PAD_ZERO_RIGHT);
		send_num(MODE_LHEX, 32'hDEAD_BEEF, 6'd0, PAD_SPACE_LEFT);
		send_num(MODE_UHEX, 32'hDEAD_BEEF, 6'd12, PAD_ZERO_LEFT);
		send_num(MODE_LHEX, 32'h0123_ABCD, 6'd9, PAD_SPACE_RIGHT);
		send_num(MODE_UHEX, 32'hFFFF_FFFF, 6'd63, PAD_SPACE_LEFT);
		send_num(MODE_LHEX, 32'd0, 6'd1, PAD_ZERO_RIGHT);
		send_num(MODE_UHEX, 32'h0000_000A, 6'd3, PAD_SPACE_LEFT);
		wait_fields_done();
	endtask

	task automatic test_random();
		for (int i = 0; i < RANDOM_FIELDS; i++) begin
			src_gaps  = !(i >= 120 && i < 200);
			sink_gaps = src_gaps;
			send_num(mode_t'($urandom_range(3)), pick_value(), pick_width(),
				2'($urandom_range(3)));
		end
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		wait_fields_done();
	endtask

	// stall the output long enough for the input to back up
	task automatic test_backpressure();
		src_gaps = 1'b0;
		hold_asked++;
		repeat (30) begin
			send_num(mode_t'($urandom_range(3)), pick_value(), pick_width(),
				2'($urandom_range(3)));
		end
		src_gaps = 1'b1;
		wait_fields_done();
	endtask

	initial begin : sink_side
		int hold_left;
		hold_left     = 0;
		text_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = SINK_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				text_ch.ready <= 1'b0;
			end else begin
				text_ch.ready <= !(sink_gaps && $urandom_range(99) < 15);
			end
		end
	end

	always @(posedge clk) begin : check_text
		text_char_t want;
		if (arst_n && text_ch.valid && text_ch.ready) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char 0x%0h last %0b",
					text_ch.out_char, text_ch.last));
			end else begin
				want = pending_chars.pop_front();
				chars_checked++;
				if (text_ch.out_char !== want.ch) begin
					report_mismatch($sformatf("out_char 0x%0h, expected 0x%0h",
						text_ch.out_char, want.ch));
				end
				if (text_ch.last !== want.last) begin
					report_mismatch($sformatf("last %0b, expected %0b on char 0x%0h",
						text_ch.last, want.last, want.ch));
				end
				if (want.last) begin
					fields_done++;
				end
			end
		end
	end

	initial begin
		#1_000_000;
		$display("Timeout with %0d characters still expected", pending_chars.size());
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		num_ch.valid       = 1'b0;
		num_ch.mode        = MODE_SDEC;
		num_ch.value       = 32'd0;
		num_ch.field_width = 6'd0;
		num_ch.pad_flags   = PAD_SPACE_LEFT;
		src_gaps           = 1'b1;
		sink_gaps          = 1'b1;
		hold_asked         = 0;
		hold_seen          = 0;
		mismatches         = 0;
		fields_sent        = 0;
		fields_done        = 0;
		chars_checked      = 0;
		mode_fields        = '{0, 0, 0, 0};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d fields, checked %0d fields and %0d characters.",
			fields_sent, fields_done, chars_checked);
		$display("Mix: %0d signed, %0d unsigned, %0d hex; all pad modes, idling and a long hold.",
			mode_fields[MODE_SDEC], mode_fields[MODE_UDEC],
			mode_fields[MODE_LHEX] + mode_fields[MODE_UHEX]);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
